[hdl/llenv_pkg.sv]
// ----------------------------------------------------------------------------
// Latitude/longitude environment map lookup: shared definitions
// Fixed-point formats, store geometry, the CORDIC angle table and the
// sideband record that travels with each transaction through the pipeline.
// ----------------------------------------------------------------------------
package llenv_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 512;
    localparam int CORDIC_STEPS = 16;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int WCFG_W  = 11;
    localparam int HCFG_W  = 10;
    localparam int DIR_W   = 16;
    localparam int CH_W    = 16;
    localparam int TEX_W   = 3 * CH_W;
    localparam int SCL_W   = DIR_W + 8;
    localparam int VEC_W   = 28;
    localparam int ANG_W   = 27;
    localparam int SQ_W    = 48;
    localparam int ROOT_W  = 24;
    localparam int REM_W   = ROOT_W + 3;
    localparam int PX_W    = 20;
    localparam int PY_W    = 19;
    localparam int POSX_W  = 19;
    localparam int POSY_W  = 18;
    localparam int PADDR_W = 3;

    localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(8388608);
    localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(4194304);

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef struct packed {
        logic               lookup;
        logic [COL_W-1:0]   wcol;
        logic [ROW_W-1:0]   wrow;
        logic [TEX_W-1:0]   wdata;
        logic               xz_zero;
        logic               all_zero;
    } item_t;

    // atan(2^-i) in turns with 24 fraction bits.
    function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
        case (i)
            0:  return ANG_W'(2097152);
            1:  return ANG_W'(1238021);
            2:  return ANG_W'(654136);
            3:  return ANG_W'(332050);
            4:  return ANG_W'(166669);
            5:  return ANG_W'(83420);
            6:  return ANG_W'(41718);
            7:  return ANG_W'(20860);
            8:  return ANG_W'(10430);
            9:  return ANG_W'(5215);
            10: return ANG_W'(2608);
            11: return ANG_W'(1304);
            12: return ANG_W'(652);
            13: return ANG_W'(326);
            14: return ANG_W'(163);
            15: return ANG_W'(81);
            16: return ANG_W'(41);
            17: return ANG_W'(20);
            18: return ANG_W'(10);
            19: return ANG_W'(5);
            20: return ANG_W'(3);
            21: return ANG_W'(1);
            22: return ANG_W'(1);
            default: return '0;
        endcase
    endfunction

endpackage

[hdl/llenv_cordic.sv]
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// Returns atan2(vec_y, vec_x) in turns, one stage for the half-turn
// pre-rotation and one stage per micro-rotation.
// ----------------------------------------------------------------------------
module llenv_cordic (
    input  logic                               clk,
    input  logic                               adv,
    input  logic signed [llenv_pkg::VEC_W-1:0] vec_y,
    input  logic signed [llenv_pkg::VEC_W-1:0] vec_x,
    output logic signed [llenv_pkg::ANG_W-1:0] angle
);
    import llenv_pkg::*;

    logic signed [VEC_W-1:0] vx_reg  [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0] vy_reg  [0:CORDIC_STEPS];
    logic signed [ANG_W-1:0] ang_reg [0:CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (vec_x < 0)
            begin
                ang_reg[0] <= (vec_y >= 0) ? ANG_HALF : -ANG_HALF;
                vx_reg[0]  <= -vec_x;
                vy_reg[0]  <= -vec_y;
            end
            else
            begin
                ang_reg[0] <= '0;
                vx_reg[0]  <= vec_x;
                vy_reg[0]  <= vec_y;
            end
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (vy_reg[k-1] >= 0)
                begin
                    vx_reg[k]  <= vx_reg[k-1] + (vy_reg[k-1] >>> (k-1));
                    vy_reg[k]  <= vy_reg[k-1] - (vx_reg[k-1] >>> (k-1));
                    ang_reg[k] <= ang_reg[k-1] + atan_turn(k-1);
                end
                else
                begin
                    vx_reg[k]  <= vx_reg[k-1] - (vy_reg[k-1] >>> (k-1));
                    vy_reg[k]  <= vy_reg[k-1] + (vx_reg[k-1] >>> (k-1));
                    ang_reg[k] <= ang_reg[k-1] - atan_turn(k-1);
                end
            end
        end
    end

    assign angle = ang_reg[CORDIC_STEPS];

endmodule

[hdl/latlong_env_map_lookup_unit.sv]
// ----------------------------------------------------------------------------
// Latitude/longitude environment map lookup unit
// Stores an RGB environment map and returns the nearest texel for a
// light-space direction.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Carries
//  request   req_valid/req_stall  action, texel write or direction
//  response  rsp_valid/rsp_stall  position, texel coordinates, RGB
//  config    APB write/read       map_width (0x0), map_height (0x4)
//
// One transaction enters per cycle while the response is not stalled. A lookup
// passes from acceptance to response through squares, 24 square-root stages, the
// CORDIC pipelines, clamp, multiply and the texel store read. Writes reach the
// store at the same pipeline stage as lookup reads, so order is kept.
// A stalled response freezes the whole pipeline. Reset clears the valid bits
// and the configuration registers; the data registers and texel store have no reset.
module latlong_env_map_lookup_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [llenv_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                action,
    input  logic [llenv_pkg::COL_W-1:0]         write_col,
    input  logic [llenv_pkg::ROW_W-1:0]         write_row,
    input  logic [llenv_pkg::CH_W-1:0]          write_red,
    input  logic [llenv_pkg::CH_W-1:0]          write_green,
    input  logic [llenv_pkg::CH_W-1:0]          write_blue,
    input  logic signed [llenv_pkg::DIR_W-1:0]  dir_x,
    input  logic signed [llenv_pkg::DIR_W-1:0]  dir_y,
    input  logic signed [llenv_pkg::DIR_W-1:0]  dir_z,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [llenv_pkg::POSX_W-1:0]        pos_x,
    output logic [llenv_pkg::POSY_W-1:0]        pos_y,
    output logic [llenv_pkg::COL_W-1:0]         texel_col,
    output logic [llenv_pkg::ROW_W-1:0]         texel_row,
    output logic [llenv_pkg::CH_W-1:0]          red,
    output logic [llenv_pkg::CH_W-1:0]          green,
    output logic [llenv_pkg::CH_W-1:0]          blue
);
    import llenv_pkg::*;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int CL         = CORDIC_STEPS + 1;

    // Configuration
    logic [WCFG_W-1:0] map_width_reg;
    logic [HCFG_W-1:0] map_height_reg;
    logic [WCFG_W-1:0] w_eff;
    logic [HCFG_W-1:0] h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= WCFG_W'(1024);
            map_height_reg <= HCFG_W'(512);
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_MAP_WIDTH:  map_width_reg  <= pwdata[WCFG_W-1:0];
                REG_MAP_HEIGHT: map_height_reg <= pwdata[HCFG_W-1:0];
                default:        map_width_reg  <= map_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAP_WIDTH:  prdata = {{(32-WCFG_W){1'b0}}, map_width_reg};
            REG_MAP_HEIGHT: prdata = {{(32-HCFG_W){1'b0}}, map_height_reg};
            default:        prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    assign w_eff = (map_width_reg == '0) ? WCFG_W'(1) :
                   (32'(map_width_reg) > MAX_WIDTH) ? WCFG_W'(MAX_WIDTH) : map_width_reg;
    assign h_eff = (map_height_reg == '0) ? HCFG_W'(1) :
                   (32'(map_height_reg) > MAX_HEIGHT) ? HCFG_W'(MAX_HEIGHT) : map_height_reg;

    // Pipeline control
    logic out_valid_reg;
    logic adv;

    assign adv       = !(out_valid_reg && rsp_stall);
    assign req_stall = !adv;

    // Stage A: input register
    logic                    a_valid_reg;
    item_t                   a_item_reg;
    logic signed [DIR_W-1:0] a_x_reg, a_y_reg, a_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg.lookup   <= (action == ACT_LOOKUP);
            a_item_reg.wcol     <= write_col;
            a_item_reg.wrow     <= write_row;
            a_item_reg.wdata    <= {write_red, write_green, write_blue};
            a_item_reg.xz_zero  <= (dir_x == '0) && (dir_z == '0);
            a_item_reg.all_zero <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
            a_x_reg <= dir_x;
            a_y_reg <= dir_y;
            a_z_reg <= dir_z;
        end
    end

    // Stage B: squares
    logic                    b_valid_reg;
    item_t                   b_item_reg;
    logic [31:0]             b_sqx_reg, b_sqz_reg;
    logic signed [SCL_W-1:0] b_x_reg, b_y_reg, b_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_item_reg <= a_item_reg;
            b_sqx_reg  <= 32'(a_x_reg * a_x_reg);
            b_sqz_reg  <= 32'(a_z_reg * a_z_reg);
            b_x_reg    <= {a_x_reg, 8'b0};
            b_y_reg    <= {a_y_reg, 8'b0};
            b_z_reg    <= {a_z_reg, 8'b0};
        end
    end

    // Square-root pipeline, one root bit per stage; stage 0 holds the radicand.
    logic                    s_valid_reg [0:SQRT_STEPS];
    item_t                   s_item_reg  [0:SQRT_STEPS];
    logic [SQ_W-1:0]         s_n_reg     [0:SQRT_STEPS];
    logic [REM_W-1:0]        s_rem_reg   [0:SQRT_STEPS];
    logic [ROOT_W-1:0]       s_root_reg  [0:SQRT_STEPS];
    logic signed [SCL_W-1:0] s_x_reg     [0:SQRT_STEPS];
    logic signed [SCL_W-1:0] s_y_reg     [0:SQRT_STEPS];
    logic signed [SCL_W-1:0] s_z_reg     [0:SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg[0] <= 1'b0;
        else if (adv)
            s_valid_reg[0] <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_item_reg[0] <= b_item_reg;
            s_n_reg[0]    <= {(SQ_W'(b_sqx_reg) + SQ_W'(b_sqz_reg))} << 16;
            s_rem_reg[0]  <= '0;
            s_root_reg[0] <= '0;
            s_x_reg[0]    <= b_x_reg;
            s_y_reg[0]    <= b_y_reg;
            s_z_reg[0]    <= b_z_reg;
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_sqrt
        logic [REM_W-1:0] rem_shift;
        logic [REM_W-1:0] trial;

        assign rem_shift = {s_rem_reg[k-1][REM_W-3:0], s_n_reg[k-1][SQ_W-1:SQ_W-2]};
        assign trial     = {1'b0, s_root_reg[k-1], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                s_valid_reg[k] <= 1'b0;
            else if (adv)
                s_valid_reg[k] <= s_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_item_reg[k] <= s_item_reg[k-1];
                s_n_reg[k]    <= s_n_reg[k-1] << 2;
                s_x_reg[k]    <= s_x_reg[k-1];
                s_y_reg[k]    <= s_y_reg[k-1];
                s_z_reg[k]    <= s_z_reg[k-1];
                if (rem_shift >= trial)
                begin
                    s_rem_reg[k]  <= rem_shift - trial;
                    s_root_reg[k] <= {s_root_reg[k-1][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    s_rem_reg[k]  <= rem_shift;
                    s_root_reg[k] <= {s_root_reg[k-1][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Longitude and latitude CORDICs run side by side.
    logic signed [ANG_W-1:0] lon_ang, lat_ang;

    llenv_cordic u_lon (
        .clk   (clk),
        .adv   (adv),
        .vec_y (VEC_W'(s_x_reg[SQRT_STEPS])),
        .vec_x (VEC_W'(s_z_reg[SQRT_STEPS])),
        .angle (lon_ang)
    );

    llenv_cordic u_lat (
        .clk   (clk),
        .adv   (adv),
        .vec_y (VEC_W'(s_y_reg[SQRT_STEPS])),
        .vec_x (signed'(VEC_W'(s_root_reg[SQRT_STEPS]))),
        .angle (lat_ang)
    );

    logic  c_valid_reg [0:CL-1];
    item_t c_item_reg  [0:CL-1];

    for (genvar k = 0; k < CL; k++)
    begin : g_delay
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    c_valid_reg[k] <= 1'b0;
                else if (adv)
                    c_valid_reg[k] <= s_valid_reg[SQRT_STEPS];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    c_item_reg[k] <= s_item_reg[SQRT_STEPS];
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    c_valid_reg[k] <= 1'b0;
                else if (adv)
                    c_valid_reg[k] <= c_valid_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    c_item_reg[k] <= c_item_reg[k-1];
            end
        end
    end

    // Stage M1: special cases and clamp
    logic                    m1_valid_reg;
    item_t                   m1_item_reg;
    logic signed [ANG_W-1:0] m1_lon_reg, m1_lat_reg;
    logic signed [ANG_W-1:0] lon_c, lat_c;

    always_comb
    begin
        if (c_item_reg[CL-1].xz_zero)
            lon_c = '0;
        else if (lon_ang > ANG_HALF)
            lon_c = ANG_HALF;
        else if (lon_ang < -ANG_HALF)
            lon_c = -ANG_HALF;
        else
            lon_c = lon_ang;

        if (c_item_reg[CL-1].all_zero)
            lat_c = '0;
        else if (lat_ang > ANG_QUARTER)
            lat_c = ANG_QUARTER;
        else if (lat_ang < -ANG_QUARTER)
            lat_c = -ANG_QUARTER;
        else
            lat_c = lat_ang;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else if (adv)
            m1_valid_reg <= c_valid_reg[CL-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_item_reg <= c_item_reg[CL-1];
            m1_lon_reg  <= ANG_HALF - lon_c;
            m1_lat_reg  <= ANG_QUARTER - lat_c;
        end
    end

    // Stage M2: scale to pixel position
    logic              m2_valid_reg;
    item_t             m2_item_reg;
    logic [PX_W-1:0]   m2_px_reg;
    logic [PY_W-1:0]   m2_py_reg;
    logic [35:0]       prod_x;
    logic [33:0]       prod_y;

    assign prod_x = 36'(m1_lon_reg[24:0]) * 36'(w_eff);
    assign prod_y = 34'(m1_lat_reg[23:0]) * 34'(h_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_valid_reg <= 1'b0;
        else if (adv)
            m2_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_item_reg <= m1_item_reg;
            m2_px_reg   <= prod_x[35:16];
            m2_py_reg   <= prod_y[33:15];
        end
    end

    // Texel store access and output registers
    logic [TEX_W-1:0]  texel_mem [0:DEPTH-1];
    logic [TEX_W-1:0]  rdata_reg;
    logic [11:0]       col_raw;
    logic [10:0]       row_raw;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [POSX_W-1:0] pos_x_reg;
    logic [POSY_W-1:0] pos_y_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    assign col_raw  = m2_px_reg[PX_W-1:8];
    assign row_raw  = m2_py_reg[PY_W-1:8];
    assign col_next = (12'(col_raw) > 12'(w_eff - 1'b1)) ? COL_W'(w_eff - 1'b1)
                                                         : col_raw[COL_W-1:0];
    assign row_next = (11'(row_raw) > 11'(h_eff - 1'b1)) ? ROW_W'(h_eff - 1'b1)
                                                         : row_raw[ROW_W-1:0];
    assign mem_addr = m2_item_reg.lookup ? {row_next, col_next}
                                         : {m2_item_reg.wrow, m2_item_reg.wcol};
    assign mem_we   = m2_valid_reg && !m2_item_reg.lookup
                   && (32'(m2_item_reg.wcol) < MAX_WIDTH)
                   && (32'(m2_item_reg.wrow) < MAX_HEIGHT);

    always_ff @(posedge clk)
    begin
        if (adv && m2_valid_reg)
        begin
            if (mem_we)
                texel_mem[mem_addr] <= m2_item_reg.wdata;
            else
                rdata_reg <= texel_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= m2_valid_reg && m2_item_reg.lookup;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x_reg <= m2_px_reg[POSX_W-1:0];
            pos_y_reg <= m2_py_reg[POSY_W-1:0];
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign texel_col = col_reg;
    assign texel_row = row_reg;
    assign red       = rdata_reg[TEX_W-1:2*CH_W];
    assign green     = rdata_reg[2*CH_W-1:CH_W];
    assign blue      = rdata_reg[CH_W-1:0];

    // Checks
    a_col_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (11'(col_reg) < w_eff))
        else $error("texel column beyond map width");

    a_row_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (10'(row_reg) < h_eff))
        else $error("texel row beyond map height");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (20'(pos_x_reg) <= (20'(w_eff) << 8)))
        else $error("horizontal position beyond map width");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_stall) |=> ($stable(m2_valid_reg) && $stable(m2_px_reg)))
        else $error("pipeline moved while response stalled");

endmodule

[tb/sv/tb_latlong_env_map_lookup_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the latitude/longitude environment map lookup unit
// Texel writes and direction lookups are streamed through the request port
// under random idling on both sides. An in-bench fixed-point CORDIC
// predictor computes the position, the texel coordinates and the fetched
// texel of every lookup. Map sizes change through the APB port between phases.
// ----------------------------------------------------------------------------
module tb_latlong_env_map_lookup_unit;
    import llenv_pkg::*;

    localparam longint HALF_TURN    = 64'sd8388608;
    localparam longint QUARTER_TURN = 64'sd4194304;
    localparam int     PIPE_CYCLES  = CORDIC_STEPS + 31;

    typedef struct {
        action_t               act;
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
        logic [CH_W-1:0]       r, g, b;
        logic signed [15:0]    x, y, z;
    } req_item_t;

    typedef struct {
        logic [POSX_W-1:0]     px;
        logic [POSY_W-1:0]     py;
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
        logic [CH_W-1:0]       r, g, b;
    } texel_hit_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic                   action = 1'b0;
    logic [COL_W-1:0]       write_col = '0;
    logic [ROW_W-1:0]       write_row = '0;
    logic [CH_W-1:0]        write_red = '0, write_green = '0, write_blue = '0;
    logic signed [DIR_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic [POSX_W-1:0]      pos_x;
    logic [POSY_W-1:0]      pos_y;
    logic [COL_W-1:0]       texel_col;
    logic [ROW_W-1:0]       texel_row;
    logic [CH_W-1:0]        red, green, blue;

    latlong_env_map_lookup_unit dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    req_item_t   pending_q[$];
    texel_hit_t  expected_hits[$];
    req_item_t   in_flight;
    logic [47:0] map_texels [int];
    bit          texel_loaded [0:DEPTH-1];
    int          map_w_reg = 1024, map_h_reg = 512;
    int          gen_w = 1024, gen_h = 512;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    const longint atan_tab [0:15] = '{2097152, 1238021, 654136, 332050, 166669,
        83420, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    function automatic int clamp_size(int v, int lim);
        return (v == 0) ? 1 : ((v > lim) ? lim : v);
    endfunction

    function automatic longint vector_angle(longint a, longint b);
        longint ang = 0, vx = b, vy = a, dx, dy;
        if (vx < 0)
        begin
            ang = (vy >= 0) ? HALF_TURN : -HALF_TURN;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx += dx; vy -= dy; ang += atan_tab[i];
            end
            else
            begin
                vx -= dx; vy += dy; ang -= atan_tab[i];
            end
        end
        return ang;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res = 0, bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // Position and texel coordinates of a direction; the texel data is left zero.
    function automatic texel_hit_t locate_texel(longint x, longint y, longint z,
                                                int w, int h);
        texel_hit_t hit;
        longint lon, lat, px, py, col, row;
        if (x == 0 && z == 0)
        begin
            lon = 0;
            lat = (y == 0) ? 0 : vector_angle(y * 256, 0);
        end
        else
        begin
            lon = vector_angle(x * 256, z * 256);
            lat = vector_angle(y * 256, int_sqrt(longint'(x * x + z * z) << 16));
        end
        lon = (lon < -HALF_TURN) ? -HALF_TURN : ((lon > HALF_TURN) ? HALF_TURN : lon);
        lat = (lat < -QUARTER_TURN) ? -QUARTER_TURN :
              ((lat > QUARTER_TURN) ? QUARTER_TURN : lat);
        px = ((HALF_TURN - lon) * w) >> 16;
        py = ((QUARTER_TURN - lat) * 2 * h) >> 16;
        col = px >> 8;
        if (col > w - 1)
            col = w - 1;
        row = py >> 8;
        if (row > h - 1)
            row = h - 1;
        hit.px = px[POSX_W-1:0];
        hit.py = py[POSY_W-1:0];
        hit.col = col[COL_W-1:0];
        hit.row = row[ROW_W-1:0];
        hit.r = '0; hit.g = '0; hit.b = '0;
        return hit;
    endfunction

    task automatic predict_transaction(req_item_t it);
        texel_hit_t hit;
        logic [47:0] tx;
        if (it.act == ACT_WRITE)
            map_texels[{it.row, it.col}] = {it.r, it.g, it.b};
        else
        begin
            hit = locate_texel(it.x, it.y, it.z, clamp_size(map_w_reg, MAX_WIDTH),
                               clamp_size(map_h_reg, MAX_HEIGHT));
            tx = map_texels.exists({hit.row, hit.col}) ? map_texels[{hit.row, hit.col}] : '0;
            {hit.r, hit.g, hit.b} = tx;
            expected_hits.push_back(hit);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("t=%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Driver: presents the pending transactions and predicts each accepted one.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (req_valid && !req_stall)
            predict_transaction(in_flight);
        if (!req_valid || !req_stall)
        begin
            if (rst_n && pending_q.size() > 0 &&
                ((cycle_count > 400 && cycle_count < 900) || $urandom_range(99) >= 28))
            begin
                in_flight = pending_q.pop_front();
                req_valid   <= 1'b1;
                action      <= in_flight.act;
                write_col   <= in_flight.col;
                write_row   <= in_flight.row;
                write_red   <= in_flight.r;
                write_green <= in_flight.g;
                write_blue  <= in_flight.b;
                dir_x       <= in_flight.x;
                dir_y       <= in_flight.y;
                dir_z       <= in_flight.z;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted response against the oldest expectation.
    always @(posedge clk)
    begin
        texel_hit_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("unexpected response transaction", 1, 0);
            else
            begin
                want = expected_hits.pop_front();
                if (pos_x !== want.px) report_mismatch("pos_x", pos_x, want.px);
                if (pos_y !== want.py) report_mismatch("pos_y", pos_y, want.py);
                if (texel_col !== want.col) report_mismatch("texel_col", texel_col, want.col);
                if (texel_row !== want.row) report_mismatch("texel_row", texel_row, want.row);
                if (red !== want.r) report_mismatch("red", red, want.r);
                if (green !== want.g) report_mismatch("green", green, want.g);
                if (blue !== want.b) report_mismatch("blue", blue, want.b);
            end
        end
        rsp_stall <= (cycle_count > 400 && cycle_count < 900) ? 1'b0
                     : ($urandom_range(99) < 28);
    end

    task automatic queue_write(int col, int row);
        req_item_t it;
        it.act = ACT_WRITE;
        it.col = COL_W'(col); it.row = ROW_W'(row);
        it.r = CH_W'($urandom); it.g = CH_W'($urandom); it.b = CH_W'($urandom);
        it.x = DIR_W'($urandom); it.y = DIR_W'($urandom); it.z = DIR_W'($urandom);
        texel_loaded[{it.row, it.col}] = 1'b1;
        pending_q.push_back(it);
    endtask

    // A texel that a lookup will hit is loaded first if it has never been.
    task automatic queue_lookup(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
        req_item_t it;
        texel_hit_t hit;
        hit = locate_texel(x, y, z, gen_w, gen_h);
        if (!texel_loaded[{hit.row, hit.col}])
            queue_write(hit.col, hit.row);
        it.act = ACT_LOOKUP;
        it.col = COL_W'($urandom); it.row = ROW_W'($urandom);
        it.r = CH_W'($urandom); it.g = CH_W'($urandom); it.b = CH_W'($urandom);
        it.x = x; it.y = y; it.z = z;
        pending_q.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || req_valid || expected_hits.size() > 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 10) @(posedge clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] reg_idx, int value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * reg_idx); pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (reg_idx == REG_MAP_WIDTH)
            map_w_reg = value & 32'h7FF;
        else
            map_h_reg = value & 32'h3FF;
    endtask

    task automatic set_map_size(int w, int h);
        apb_write(REG_MAP_WIDTH, w);
        apb_write(REG_MAP_HEIGHT, h);
        gen_w = clamp_size(map_w_reg, MAX_WIDTH);
        gen_h = clamp_size(map_h_reg, MAX_HEIGHT);
    endtask

    task automatic random_phase(int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(9);
            if (sel < 2)
                queue_write($urandom_range(1023), $urandom_range(511));
            else if (sel < 6)
                queue_lookup(DIR_W'($urandom), DIR_W'($urandom), DIR_W'($urandom));
            else if (sel < 9)
                queue_lookup(DIR_W'($urandom_range(32768) - 16384),
                             DIR_W'($urandom_range(32768) - 16384),
                             DIR_W'($urandom_range(32768) - 16384));
            else
                queue_lookup(DIR_W'($urandom_range(6) - 3), DIR_W'($urandom_range(6) - 3),
                             DIR_W'($urandom_range(6) - 3));
        end
    endtask

    initial
    begin
        int sizes [0:5][0:1] = '{'{1, 1}, '{0, 0}, '{7, 5}, '{2047, 1023},
                                 '{64, 32}, '{1024, 512}};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed: store corners, axes, extremes, zero and vertical directions.
        queue_write(1023, 511);
        queue_write(0, 0);
        queue_write(1023, 0);
        queue_lookup(0, 0, 0);
        queue_lookup(0, 16384, 0);
        queue_lookup(0, -16384, 0);
        queue_lookup(0, 32767, 0);
        queue_lookup(0, -32768, 0);
        queue_lookup(16384, 0, 0);
        queue_lookup(-16384, 0, 0);
        queue_lookup(0, 0, 16384);
        queue_lookup(0, 0, -16384);
        queue_lookup(-1, 0, -16384);
        queue_lookup(32767, 32767, 32767);
        queue_lookup(-32768, -32768, -32768);
        queue_lookup(-32768, 32767, -32768);
        queue_lookup(32767, -32768, -1);
        queue_lookup(1, 1, -1);
        random_phase(60);
        // Hold the sender until the pipeline has fully drained.
        wait_idle();

        foreach (sizes[p])
        begin
            set_map_size(sizes[p][0], sizes[p][1]);
            queue_lookup(0, 0, -16384);
            queue_lookup(32767, -32768, -32768);
            random_phase(55);
            wait_idle();
        end

        if (mismatches == 0 && expected_hits.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
